[src/lfs_pkg.sv]
package lfs_pkg;

	// Field widths of the channels.
	localparam int WIDTH_W = 8;
	localparam int POS_W   = 7;
	localparam int SPEED_W = 15;
	localparam int THR_W   = 8;
	localparam int DRIVE_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	// Speed ratio numerator: the ratio is RATIO_FULL / 320 at most and RATIO_MIN / 320 at least.
	localparam int RATIO_W = 9;
	localparam logic [RATIO_W-1:0] RATIO_FULL = 9'd320;
	localparam logic [RATIO_W-1:0] RATIO_MIN  = 9'd64;
	// Error magnitudes up to this value keep full speed.
	localparam int DEAD_ZONE = 6;
	// Error magnitudes from this value on sit on the minimum ratio.
	localparam int RATIO_KNEE = 64;
	// Reciprocal of five in 16 fractional bits, rounded down.
	localparam logic [13:0] RECIP5 = 14'd13107;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE     = 3'd0,
		REG_BASE_SPEED = 3'd1,
		REG_MIN_SPEED  = 3'd2,
		REG_MAX_SPEED  = 3'd3,
		REG_MAX_TURN   = 3'd4,
		REG_LOST_THR   = 3'd5
	} lfs_reg_t;

	// Reset values of the registers.
	localparam logic [SPEED_W-1:0] BASE_SPEED_RST = 15'd3000;
	localparam logic [SPEED_W-1:0] MIN_SPEED_RST  = 15'd1000;
	localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = 15'd6000;
	localparam logic [SPEED_W-1:0] MAX_TURN_RST   = 15'd2000;
	localparam logic [THR_W-1:0]   LOST_THR_RST   = 8'd5;

	// Turn direction codes, two bits two's complement.
	localparam logic signed [1:0] DIR_NONE  = 2'sb00;
	localparam logic signed [1:0] DIR_LEFT  = 2'sb11;
	localparam logic signed [1:0] DIR_RIGHT = 2'sb01;

endpackage

[src/lfs_ifs.sv]
// Line-sensor frame channel.
interface lfs_frame_if import lfs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [WIDTH_W-1:0] stripe_width;
	logic [POS_W-1:0]   line_position;

	modport source (output valid, output stripe_width, output line_position, input ready);
	modport sink   (input valid, input stripe_width, input line_position, output ready);
endinterface

// Wheel drive result channel.
interface lfs_drive_if import lfs_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] left_drive;
	logic signed [DRIVE_W-1:0] right_drive;
	logic                      searching;

	modport source (output valid, output left_drive, output right_drive, output searching,
		input ready);
	modport sink   (input valid, input left_drive, input right_drive, input searching,
		output ready);
endinterface

// Configuration write channel.
interface lfs_cfg_if import lfs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[src/line_follow_steering.sv]
// Channel | Role   | Payload
// frame   | sink   | stripe_width[7:0], line_position[6:0]
// drive   | source | left_drive[15:0] signed, right_drive[15:0] signed, searching
// cfg     | sink   | index[2:0], data[14:0], always ready
//
// A tracking item passes from its acceptance through six steps, MUL1, MUL2, DIV, MUL3, TURN and
// OUT (three on the one shared multiplier), with frame.ready low until OUT has loaded the result.
// A search-spin item goes from acceptance straight to OUT, which loads its result; an item
// taken while disabled gives no result.
// arst_n clears the sequencer, counter, turn direction and result slot, loads reset values.
// A stalled drive channel holds the sequencer in its last step until the result slot frees.
module line_follow_steering import lfs_pkg::*; #(
	parameter int SENSOR_CENTER = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	lfs_frame_if.sink    frame,
	lfs_drive_if.source  drive,
	lfs_cfg_if.sink      cfg
);

	// Error width covers line positions minus the center, magnitude one bit less.
	localparam int EW  = $clog2(SENSOR_CENTER + 128) + 1;
	// Shared multiplier operand and product widths.
	localparam int MAW = 19;
	localparam int MBW = (EW > 15) ? EW : 15;
	localparam int PW  = MAW + MBW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_DIV,
		S_MUL3,
		S_TURN,
		S_OUT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic               enable_q;
	logic [SPEED_W-1:0] base_q;
	logic [SPEED_W-1:0] min_q;
	logic [SPEED_W-1:0] max_q;
	logic [SPEED_W-1:0] turn_max_q;
	logic [THR_W-1:0]   thr_q;

	// Block state and working registers.
	logic [7:0]               lost_q;
	logic signed [1:0]        dir_q;
	logic                     srch_q;
	logic signed [EW-1:0]     e_q;
	logic [RATIO_W-1:0]       r_q;
	logic signed [PW-1:0]     prod_q;
	logic [17:0]              y_q;
	logic [SPEED_W-1:0]       speed_q;
	logic signed [DRIVE_W-1:0] turn_q;
	logic                      out_valid_q;
	logic signed [DRIVE_W-1:0] left_q;
	logic signed [DRIVE_W-1:0] right_q;
	logic                      searching_q;

	logic in_acc;
	logic out_free;

	assign frame.ready = (state_q == S_IDLE);
	assign in_acc      = frame.valid && frame.ready;
	assign out_free    = !out_valid_q || drive.ready;

	assign cfg.ready         = 1'b1;
	assign drive.valid       = out_valid_q;
	assign drive.left_drive  = left_q;
	assign drive.right_drive = right_q;
	assign drive.searching   = searching_q;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b1;
			base_q     <= BASE_SPEED_RST;
			min_q      <= MIN_SPEED_RST;
			max_q      <= MAX_SPEED_RST;
			turn_max_q <= MAX_TURN_RST;
			thr_q      <= LOST_THR_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (lfs_reg_t'(cfg.index))
				REG_ENABLE:     enable_q   <= cfg.data[0];
				REG_BASE_SPEED: base_q     <= cfg.data;
				REG_MIN_SPEED:  min_q      <= cfg.data;
				REG_MAX_SPEED:  max_q      <= cfg.data;
				REG_MAX_TURN:   turn_max_q <= cfg.data;
				REG_LOST_THR:   thr_q      <= cfg.data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Position error, its magnitude and the speed ratio numerator of the incoming frame.
	logic signed [EW-1:0] e_c;
	logic [EW-2:0]        mag_c;
	logic [RATIO_W-1:0]   r_c;
	logic [7:0]           lost_inc_c;
	logic                 blank_c;
	logic                 spin_c;

	always_comb begin
		e_c   = $signed(EW'(frame.line_position)) - $signed(EW'(SENSOR_CENTER));
		mag_c = e_c[EW-1] ? (EW-1)'(-e_c) : e_c[EW-2:0];
		if (mag_c <= (EW-1)'(DEAD_ZONE)) begin
			r_c = RATIO_FULL;
		end else if (mag_c >= (EW-1)'(RATIO_KNEE)) begin
			r_c = RATIO_MIN;
		end else begin
			r_c = RATIO_FULL - RATIO_W'({mag_c[5:0], 2'b00});
		end
		lost_inc_c = (lost_q == 8'hFF) ? lost_q : lost_q + 8'd1;
		blank_c    = (frame.stripe_width == '0);
		spin_c     = blank_c && (lost_inc_c > thr_q);
	end

	// Operand selection of the shared multiplier.
	logic signed [MAW-1:0] mul_a;
	logic signed [MBW-1:0] mul_b;
	logic signed [PW-1:0]  mul_p;

	always_comb begin
		unique case (state_q)
			S_MUL1: begin
				mul_a = $signed(MAW'(base_q));
				mul_b = $signed(MBW'(r_q));
			end
			S_MUL2: begin
				mul_a = $signed(MAW'(prod_q[23:6]));
				mul_b = $signed(MBW'(RECIP5));
			end
			S_MUL3: begin
				mul_a = $signed(MAW'(speed_q));
				mul_b = MBW'(e_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = PW'(mul_a) * PW'(mul_b);
	end

	// Divide by five with one correction step, then clamp the speed.
	logic [14:0]        q0_c;
	logic [17:0]        rem_c;
	logic [15:0]        sp_raw_c;
	logic [SPEED_W-1:0] speed_c;

	always_comb begin
		q0_c     = prod_q[30:16];
		rem_c    = y_q - ({3'b000, q0_c} + {1'b0, q0_c, 2'b00});
		sp_raw_c = (rem_c >= 18'd5) ? 16'(q0_c) + 16'd1 : 16'(q0_c);
		if (sp_raw_c > 16'(base_q)) begin
			speed_c = base_q;
		end else if (sp_raw_c < 16'(min_q)) begin
			speed_c = min_q;
		end else begin
			speed_c = sp_raw_c[SPEED_W-1:0];
		end
	end

	// Turn term: divide by 64 toward zero, then clamp to the turn limit.
	logic signed [PW-1:0]      t_div_c;
	logic signed [PW-1:0]      t_lim_c;
	logic signed [DRIVE_W-1:0] turn_c;

	always_comb begin
		t_div_c = (prod_q + (prod_q[PW-1] ? PW'(63) : PW'(0))) >>> 6;
		t_lim_c = $signed(PW'(turn_max_q));
		if (t_div_c > t_lim_c) begin
			turn_c = DRIVE_W'(t_lim_c);
		end else if (t_div_c < -t_lim_c) begin
			turn_c = DRIVE_W'(-t_lim_c);
		end else begin
			turn_c = DRIVE_W'(t_div_c);
		end
	end

	// Wheel levels, upper bound tested first; search spin levels.
	logic signed [DRIVE_W:0]   sum_l_c;
	logic signed [DRIVE_W:0]   sum_r_c;
	logic signed [DRIVE_W:0]   lo_c;
	logic signed [DRIVE_W:0]   hi_c;
	logic signed [DRIVE_W-1:0] left_c;
	logic signed [DRIVE_W-1:0] right_c;
	logic signed [DRIVE_W-1:0] spin_l_c;

	always_comb begin
		lo_c    = $signed((DRIVE_W+1)'(min_q));
		hi_c    = $signed((DRIVE_W+1)'(max_q));
		sum_l_c = $signed((DRIVE_W+1)'(speed_q)) - (DRIVE_W+1)'(turn_q);
		sum_r_c = $signed((DRIVE_W+1)'(speed_q)) + (DRIVE_W+1)'(turn_q);
		if (sum_l_c > hi_c) begin
			left_c = DRIVE_W'(hi_c);
		end else if (sum_l_c < lo_c) begin
			left_c = DRIVE_W'(lo_c);
		end else begin
			left_c = DRIVE_W'(sum_l_c);
		end
		if (sum_r_c > hi_c) begin
			right_c = DRIVE_W'(hi_c);
		end else if (sum_r_c < lo_c) begin
			right_c = DRIVE_W'(lo_c);
		end else begin
			right_c = DRIVE_W'(sum_r_c);
		end
		if (dir_q == DIR_RIGHT) begin
			spin_l_c = $signed(DRIVE_W'(min_q));
		end else if (dir_q == DIR_LEFT) begin
			spin_l_c = -$signed(DRIVE_W'(min_q));
		end else begin
			spin_l_c = '0;
		end
	end

	// Sequencer, block state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lost_q      <= '0;
			dir_q       <= DIR_NONE;
			out_valid_q <= 1'b0;
			srch_q      <= 1'b0;
			e_q         <= '0;
			r_q         <= '0;
			prod_q      <= '0;
			y_q         <= '0;
			speed_q     <= '0;
			turn_q      <= '0;
			left_q      <= '0;
			right_q     <= '0;
			searching_q <= 1'b0;
		end else begin
			// A taken result frees the slot unless the next one is loaded now.
			if (drive.valid && drive.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && enable_q) begin
						lost_q  <= blank_c ? lost_inc_c : 8'd0;
						srch_q  <= spin_c;
						e_q     <= e_c;
						r_q     <= r_c;
						state_q <= spin_c ? S_OUT : S_MUL1;
					end
				end
				S_MUL1: begin
					prod_q  <= mul_p;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					y_q     <= prod_q[23:6];
					prod_q  <= mul_p;
					state_q <= S_DIV;
				end
				S_DIV: begin
					speed_q <= speed_c;
					state_q <= S_MUL3;
				end
				S_MUL3: begin
					prod_q  <= mul_p;
					state_q <= S_TURN;
				end
				S_TURN: begin
					turn_q  <= turn_c;
					dir_q   <= (turn_c > 0) ? DIR_RIGHT : DIR_LEFT;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						searching_q <= srch_q;
						left_q      <= srch_q ? spin_l_c : left_c;
						right_q     <= srch_q ? -spin_l_c : right_c;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[src/lfs_checker.sv]
module lfs_checker import lfs_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [DRIVE_W-1:0] left_drive,
	input logic signed [DRIVE_W-1:0] right_drive,
	input logic                      searching
);

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(left_drive) && $stable(right_drive)
			&& $stable(searching))
		else $error("result payload changed while stalled");

	// A search spin drives the right side with the negative of the left level.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && searching |-> right_drive == -left_drive)
		else $error("search spin sides not opposite");

	// Tracking levels are clamped into a non-negative range.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !searching |-> !left_drive[DRIVE_W-1] && !right_drive[DRIVE_W-1])
		else $error("tracking level negative");

	// A new result only follows a cycle in which the block was busy with an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without work in progress");

endmodule

bind line_follow_steering lfs_checker u_lfs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (frame.ready),
	.out_valid   (drive.valid),
	.out_ready   (drive.ready),
	.left_drive  (drive.left_drive),
	.right_drive (drive.right_drive),
	.searching   (drive.searching)
);
